// ===== design/dbb_pkg.sv =====
// Package: shared constants, types and helper functions for the dark border bounding box.
`default_nettype none
package dbb_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 12;
  localparam int CNT_W      = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int QUAL_W = ((CNT_W + 3) > (SIZE_W + 2)) ? (CNT_W + 3) : (SIZE_W + 2);
  localparam int CMP_W  = SIZE_W + CFG_DATA_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [PIX_W-1:0]      DARK_LEVEL_RST   = PIX_W'(10);
  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = CFG_DATA_W'(4096);
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = CFG_DATA_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DARK_LEVEL   = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0]  dark_level;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             bright;
    logic             row_start;
    logic             last_row;
    logic             frame_end;
    logic             row_found;
    logic [ROW_W-1:0] top_row;
    logic [ROW_W-1:0] bottom_row;
  } q_entry_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] top_row;
    logic [POS_W-1:0] bottom_row;
    logic [POS_W-1:0] left_col;
    logic [POS_W-1:0] right_col;
  } result_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [CFG_DATA_W-1:0] v,
                                                   logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (CMP_W'(v) > CMP_W'(maxv)) begin
      r = maxv;
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

  function automatic logic qualifies(logic [CNT_W-1:0] cnt, logic [SIZE_W-1:0] size);
    logic [QUAL_W-1:0] lhs;
    logic [QUAL_W-1:0] rhs;
    lhs = QUAL_W'(cnt) * QUAL_W'(5);
    rhs = QUAL_W'(size) << 2;
    return lhs >= rhs;
  endfunction

endpackage
`default_nettype wire

// ===== design/dbb_ifs.sv =====
// Interfaces: pixel input, result output and configuration write channels.
`default_nettype none
interface dbb_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [dbb_pkg::PIX_W-1:0]  gray_pixel;
  modport source (output valid, output gray_pixel, input ready);
  modport sink (input valid, input gray_pixel, output ready);
endinterface

interface dbb_result_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [dbb_pkg::POS_W-1:0]  top_row;
  logic [dbb_pkg::POS_W-1:0]  bottom_row;
  logic [dbb_pkg::POS_W-1:0]  left_col;
  logic [dbb_pkg::POS_W-1:0]  right_col;
  modport source (output valid, output found, output top_row, output bottom_row,
                  output left_col, output right_col, input ready);
  modport sink (input valid, input found, input top_row, input bottom_row,
                input left_col, input right_col, output ready);
endinterface

interface dbb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dbb_pkg::CFG_IDX_W-1:0]  index;
  logic [dbb_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/dbb_front.sv =====
// Front end: accepts pixels, tracks raster position, qualifies rows and builds queue entries.
`default_nettype none
module dbb_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dbb_pkg::cfg_t             cfg_i,
  input  wire logic                      in_valid_i,
  input  wire logic [dbb_pkg::PIX_W-1:0] in_pixel_i,
  output logic                           in_ready_o,
  input  wire logic                      q_full_i,
  output logic                           push_o,
  output dbb_pkg::q_entry_t              entry_o
);

  logic [dbb_pkg::COL_W-1:0] col_q, col_d;
  logic [dbb_pkg::ROW_W-1:0] row_q, row_d;
  logic [dbb_pkg::CNT_W-1:0] rbc_q, rbc_d;
  logic [dbb_pkg::ROW_W-1:0] first_row_q, first_row_d;
  logic [dbb_pkg::ROW_W-1:0] last_row_q, last_row_d;
  logic                      row_seen_q, row_seen_d;

  logic                      bright;
  logic                      last_in_row;
  logic                      last_row_now;
  logic                      row_qual;
  logic [dbb_pkg::CNT_W-1:0] rbc_next;
  logic                      seen_next;
  logic [dbb_pkg::ROW_W-1:0] first_next;
  logic [dbb_pkg::ROW_W-1:0] last_next;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    bright       = in_pixel_i >= cfg_i.dark_level;
    last_in_row  = (dbb_pkg::SIZE_W'(col_q) + dbb_pkg::SIZE_W'(1)) >= cfg_i.width;
    last_row_now = (dbb_pkg::SIZE_W'(row_q) + dbb_pkg::SIZE_W'(1)) >= cfg_i.height;
    rbc_next     = rbc_q + dbb_pkg::CNT_W'(bright);
    row_qual     = last_in_row && dbb_pkg::qualifies(rbc_next, cfg_i.width);
    seen_next    = row_seen_q || row_qual;
    first_next   = (row_qual && !row_seen_q) ? row_q : first_row_q;
    last_next    = row_qual ? row_q : last_row_q;

    entry_o.col        = col_q;
    entry_o.bright     = bright;
    entry_o.row_start  = (row_q == '0);
    entry_o.last_row   = last_row_now;
    entry_o.frame_end  = last_in_row && last_row_now;
    entry_o.row_found  = seen_next;
    entry_o.top_row    = first_next;
    entry_o.bottom_row = last_next;

    col_d       = col_q;
    row_d       = row_q;
    rbc_d       = rbc_q;
    first_row_d = first_row_q;
    last_row_d  = last_row_q;
    row_seen_d  = row_seen_q;
    if (push_o) begin
      if (!last_in_row) begin
        col_d = col_q + dbb_pkg::COL_W'(1);
        rbc_d = rbc_next;
      end else begin
        col_d = '0;
        rbc_d = '0;
        if (!last_row_now) begin
          row_d       = row_q + dbb_pkg::ROW_W'(1);
          first_row_d = first_next;
          last_row_d  = last_next;
          row_seen_d  = seen_next;
        end else begin
          row_d       = '0;
          first_row_d = '0;
          last_row_d  = '0;
          row_seen_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      rbc_q       <= '0;
      first_row_q <= '0;
      last_row_q  <= '0;
      row_seen_q  <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      rbc_q       <= rbc_d;
      first_row_q <= first_row_d;
      last_row_q  <= last_row_d;
      row_seen_q  <= row_seen_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/dbb_queue.sv =====
// Queue: short FIFO of classified pixel entries between front and back.
`default_nettype none
module dbb_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire dbb_pkg::q_entry_t entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output dbb_pkg::q_entry_t      head_o
);

  dbb_pkg::q_entry_t           slots_q [dbb_pkg::Q_DEPTH];
  logic [dbb_pkg::Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [dbb_pkg::Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [dbb_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == dbb_pkg::Q_CNT_W'(dbb_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == dbb_pkg::Q_PTR_W'(dbb_pkg::Q_DEPTH - 1)) ? '0
               : wr_ptr_q + dbb_pkg::Q_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == dbb_pkg::Q_PTR_W'(dbb_pkg::Q_DEPTH - 1)) ? '0
               : rd_ptr_q + dbb_pkg::Q_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + dbb_pkg::Q_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - dbb_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/dbb_back.sv =====
// Back end: column count read-modify-write, column qualification and result register.
`default_nettype none
module dbb_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [dbb_pkg::SIZE_W-1:0] height_i,
  input  wire logic                       q_empty_i,
  input  wire dbb_pkg::q_entry_t          head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output dbb_pkg::result_t                out_o
);

  logic [dbb_pkg::CNT_W-1:0] col_mem [dbb_pkg::MAX_WIDTH];

  logic                      b_valid_q, b_valid_d;
  dbb_pkg::q_entry_t         b_q;
  logic [dbb_pkg::CNT_W-1:0] rdata_q;
  logic                      fwd_q, fwd_d;
  logic [dbb_pkg::CNT_W-1:0] fwd_data_q;

  logic                      col_seen_q, col_seen_d;
  logic [dbb_pkg::COL_W-1:0] first_col_q, first_col_d;
  logic [dbb_pkg::COL_W-1:0] last_col_q, last_col_d;

  logic                      out_valid_q, out_valid_d;
  dbb_pkg::result_t          out_q, out_d;

  logic                      adv;
  logic                      retire;
  logic [dbb_pkg::CNT_W-1:0] prev;
  logic [dbb_pkg::CNT_W-1:0] ccount;
  logic                      col_qual;
  logic                      seen_next;
  logic [dbb_pkg::COL_W-1:0] first_next;
  logic [dbb_pkg::COL_W-1:0] last_next;
  logic                      found;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    adv        = !b_valid_q || !(b_q.frame_end && out_valid_q && !out_ready_i);
    retire     = b_valid_q && adv;
    pop_o      = !q_empty_i && adv;
    prev       = fwd_q ? fwd_data_q : rdata_q;
    ccount     = (b_q.row_start ? '0 : prev) + dbb_pkg::CNT_W'(b_q.bright);
    col_qual   = b_q.last_row && dbb_pkg::qualifies(ccount, height_i);
    seen_next  = col_seen_q || col_qual;
    first_next = (col_qual && !col_seen_q) ? b_q.col : first_col_q;
    last_next  = col_qual ? b_q.col : last_col_q;
    found      = b_q.row_found && seen_next;

    b_valid_d   = adv ? pop_o : b_valid_q;
    fwd_d       = pop_o && retire && (head_i.col == b_q.col);
    col_seen_d  = col_seen_q;
    first_col_d = first_col_q;
    last_col_d  = last_col_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (retire) begin
      if (b_q.frame_end) begin
        col_seen_d       = 1'b0;
        first_col_d      = '0;
        last_col_d       = '0;
        out_valid_d      = 1'b1;
        out_d.found      = found;
        out_d.top_row    = found ? dbb_pkg::POS_W'(b_q.top_row) : '0;
        out_d.bottom_row = found ? dbb_pkg::POS_W'(b_q.bottom_row) : '0;
        out_d.left_col   = found ? dbb_pkg::POS_W'(first_next) : '0;
        out_d.right_col  = found ? dbb_pkg::POS_W'(last_next) : '0;
      end else begin
        col_seen_d  = seen_next;
        first_col_d = first_next;
        last_col_d  = last_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      col_seen_q  <= 1'b0;
      first_col_q <= '0;
      last_col_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      fwd_q       <= adv ? fwd_d : fwd_q;
      col_seen_q  <= col_seen_d;
      first_col_q <= first_col_d;
      last_col_q  <= last_col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (adv) begin
      b_q        <= head_i;
      fwd_data_q <= ccount;
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      col_mem[b_q.col] <= ccount;
    end
    if (pop_o) begin
      rdata_q <= col_mem[head_i.col];
    end
  end

endmodule
`default_nettype wire

// ===== design/dark_border_bounding_box.sv =====
// Top level: configuration registers, front end, entry queue and back end.
// Throughput: one pixel word per cycle, set by the column count RMW (one read, one write a cycle),
// except while an unaccepted result word holds a frame's last pixel in the back-end register.
// Back-to-back accesses to the same column are forwarded around the memory read register.
// Reset: clears position, tracking and handshake state; configuration returns to defaults.
// The column count memory is not cleared; the first row of each frame overwrites it.
`default_nettype none
module dark_border_bounding_box (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dbb_pixel_if.sink    pix_i,
  dbb_result_if.source res_o,
  dbb_cfg_if.sink      cfg_i
);

  logic [dbb_pkg::PIX_W-1:0]      dark_level_q, dark_level_d;
  logic [dbb_pkg::CFG_DATA_W-1:0] frame_width_q, frame_width_d;
  logic [dbb_pkg::CFG_DATA_W-1:0] frame_height_q, frame_height_d;

  dbb_pkg::cfg_t     cfg;
  dbb_pkg::q_entry_t entry;
  dbb_pkg::q_entry_t head;
  dbb_pkg::result_t  result;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    dark_level_d   = dark_level_q;
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_i.valid) begin
      case (dbb_pkg::cfg_idx_e'(cfg_i.index))
        dbb_pkg::CFG_DARK_LEVEL:   dark_level_d   = dbb_pkg::PIX_W'(cfg_i.data);
        dbb_pkg::CFG_FRAME_WIDTH:  frame_width_d  = cfg_i.data;
        dbb_pkg::CFG_FRAME_HEIGHT: frame_height_d = cfg_i.data;
        default: ;
      endcase
    end
    cfg.dark_level = dark_level_q;
    cfg.width  = dbb_pkg::clamp_size(frame_width_q, dbb_pkg::SIZE_W'(dbb_pkg::MAX_WIDTH));
    cfg.height = dbb_pkg::clamp_size(frame_height_q, dbb_pkg::SIZE_W'(dbb_pkg::MAX_HEIGHT));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_level_q   <= dbb_pkg::DARK_LEVEL_RST;
      frame_width_q  <= dbb_pkg::FRAME_WIDTH_RST;
      frame_height_q <= dbb_pkg::FRAME_HEIGHT_RST;
    end else begin
      dark_level_q   <= dark_level_d;
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  dbb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (pix_i.valid),
    .in_pixel_i (pix_i.gray_pixel),
    .in_ready_o (pix_i.ready),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  dbb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  dbb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .height_i    (cfg.height),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_o       (result)
  );

  assign res_o.found      = result.found;
  assign res_o.top_row    = result.top_row;
  assign res_o.bottom_row = result.bottom_row;
  assign res_o.left_col   = result.left_col;
  assign res_o.right_col  = result.right_col;

endmodule
`default_nettype wire

// ===== design/dbb_checker.sv =====
// Checker: port-level assertions on the result channel, bound to the top level.
`default_nettype none
module dbb_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic                      found_i,
  input wire logic [dbb_pkg::POS_W-1:0] top_row_i,
  input wire logic [dbb_pkg::POS_W-1:0] bottom_row_i,
  input wire logic [dbb_pkg::POS_W-1:0] left_col_i,
  input wire logic [dbb_pkg::POS_W-1:0] right_col_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_dark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> top_row_i == '0 && bottom_row_i == '0 &&
                                left_col_i == '0 && right_col_i == '0)
    else $error("all-dark result has nonzero bounds");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i |-> top_row_i <= bottom_row_i && left_col_i <= right_col_i)
    else $error("bounding box edges out of order");

endmodule

bind dark_border_bounding_box dbb_checker u_dbb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .found_i      (res_o.found),
  .top_row_i    (res_o.top_row),
  .bottom_row_i (res_o.bottom_row),
  .left_col_i   (res_o.left_col),
  .right_col_i  (res_o.right_col)
);
`default_nettype wire

// ===== tb/dbb_box_checker.sv =====
// Bounding box checker: tracks config and pixel words, predicts each frame's box, compares.
module dbb_box_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  dbb_pixel_if  pix_i,
  dbb_result_if res_i,
  dbb_cfg_if    cfg_i,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dbb_pkg::*;

  logic [PIX_W-1:0]      dark_lvl;
  logic [CFG_DATA_W-1:0] width_raw;
  logic [CFG_DATA_W-1:0] height_raw;
  logic [CNT_W-1:0]      col_tally [MAX_WIDTH];
  logic [CNT_W-1:0]      row_tally;
  logic [POS_W-1:0]      col_at;
  logic [POS_W-1:0]      row_at;
  logic [POS_W-1:0]      top_at;
  logic [POS_W-1:0]      bottom_at;
  logic [POS_W-1:0]      left_at;
  logic [POS_W-1:0]      right_at;
  logic                  row_hit;
  logic                  col_hit;
  result_t               box_q [$];
  int                    failures;

  function automatic int used_size(logic [CFG_DATA_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  task automatic restart_frame();
    row_tally = '0;
    col_at    = '0;
    row_at    = '0;
    top_at    = '0;
    bottom_at = '0;
    left_at   = '0;
    right_at  = '0;
    row_hit   = 1'b0;
    col_hit   = 1'b0;
  endtask

  task automatic take_pixel(logic [PIX_W-1:0] v);
    int               w;
    int               h;
    logic             bright;
    logic             row_end;
    logic             frame_end;
    logic [CNT_W-1:0] tally;
    result_t          box;
    w         = used_size(width_raw, MAX_WIDTH);
    h         = used_size(height_raw, MAX_HEIGHT);
    bright    = (v >= dark_lvl);
    row_end   = (int'(col_at) + 1 >= w);
    frame_end = (int'(row_at) + 1 >= h);
    if (row_at == '0) begin
      tally = CNT_W'(bright);
    end else begin
      tally = col_tally[col_at] + CNT_W'(bright);
    end
    col_tally[col_at] = tally;
    row_tally = row_tally + CNT_W'(bright);
    if (frame_end && int'(tally) * 5 >= h * 4) begin
      if (!col_hit) begin
        left_at = col_at;
        col_hit = 1'b1;
      end
      right_at = col_at;
    end
    if (!row_end) begin
      col_at = col_at + 1'b1;
    end else begin
      if (int'(row_tally) * 5 >= w * 4) begin
        if (!row_hit) begin
          top_at  = row_at;
          row_hit = 1'b1;
        end
        bottom_at = row_at;
      end
      row_tally = '0;
      col_at    = '0;
      if (!frame_end) begin
        row_at = row_at + 1'b1;
      end else begin
        box = '0;
        if (row_hit && col_hit) begin
          box.found      = 1'b1;
          box.top_row    = top_at;
          box.bottom_row = bottom_at;
          box.left_col   = left_at;
          box.right_col  = right_at;
        end
        box_q.push_back(box);
        restart_frame();
      end
    end
  endtask

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      failures++;
      $display("%0t %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  task automatic take_result();
    result_t want;
    if (box_q.size() == 0) begin
      failures++;
      $display("%0t result word with none expected: found %0d top %0d bottom %0d left %0d right %0d",
               $time, res_i.found, res_i.top_row, res_i.bottom_row, res_i.left_col,
               res_i.right_col);
    end else begin
      want = box_q.pop_front();
      check_field("found", int'(want.found), int'(res_i.found));
      check_field("top_row", int'(want.top_row), int'(res_i.top_row));
      check_field("bottom_row", int'(want.bottom_row), int'(res_i.bottom_row));
      check_field("left_col", int'(want.left_col), int'(res_i.left_col));
      check_field("right_col", int'(want.right_col), int'(res_i.right_col));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_lvl   = DARK_LEVEL_RST;
      width_raw  = FRAME_WIDTH_RST;
      height_raw = FRAME_HEIGHT_RST;
      restart_frame();
      box_q.delete();
      failures = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_DARK_LEVEL:   dark_lvl   = cfg_i.data[PIX_W-1:0];
          CFG_FRAME_WIDTH:  width_raw  = cfg_i.data;
          CFG_FRAME_HEIGHT: height_raw = cfg_i.data;
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) take_pixel(pix_i.gray_pixel);
      if (res_i.valid && res_i.ready) take_result();
    end
    fail_count_o <= failures;
    pending_o    <= box_q.size();
  end

endmodule

// ===== tb/dark_border_bounding_box_test.sv =====
// Testbench top: clock, reset, frame and config stimulus, receiver stalls and verdict.
module dark_border_bounding_box_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dbb_pkg::*;

  localparam int STUCK_LIMIT   = 4000;
  localparam int RANDOM_PIXELS = 660;

  typedef enum int {FILL_NOISE, FILL_BOX, FILL_DARK, FILL_BRIGHT, FILL_ONE_DARK} fill_e;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  int               src_idle_pct;
  int               sink_idle_pct;
  int               fail_count;
  int               pending;
  int               sent;
  int               base;
  int               frame_w;
  int               frame_h;
  logic [PIX_W-1:0] level;

  dbb_pixel_if  pix ();
  dbb_result_if res ();
  dbb_cfg_if    cfg ();

  dark_border_bounding_box dut (
    .clk_i,
    .rst_ni,
    .pix_i (pix),
    .res_o (res),
    .cfg_i (cfg)
  );

  dbb_box_checker box_check (
    .clk_i,
    .rst_ni,
    .pix_i        (pix),
    .res_i        (res),
    .cfg_i        (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #2 clk_i = ~clk_i;

  function automatic int eff_size(logic [CFG_DATA_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] dark_value();
    if (level == '0) return '0;
    if ($urandom_range(0, 3) == 0) return level - 1'b1;
    return PIX_W'($urandom_range(0, int'(level) - 1));
  endfunction

  function automatic logic [PIX_W-1:0] bright_value();
    if ($urandom_range(0, 3) == 0) return level;
    return PIX_W'($urandom_range(int'(level), 255));
  endfunction

  function automatic logic [PIX_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return PIX_W'(255);
    return PIX_W'($urandom_range(1, 254));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return '0;
    if (r == 1) return CFG_DATA_W'($urandom_range(7, 48));
    return CFG_DATA_W'($urandom_range(1, 6));
  endfunction

  task automatic push_pixel(logic [PIX_W-1:0] v);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid      <= 1'b1;
    pix.gray_pixel <= v;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    sent++;
  endtask

  // hold the stream until every box has come out and the pipeline is empty
  task automatic settle();
    pix.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_word(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
  endtask

  task automatic set_config(logic [PIX_W-1:0] lvl, logic [CFG_DATA_W-1:0] w,
                            logic [CFG_DATA_W-1:0] h);
    settle();
    write_word(CFG_DARK_LEVEL, CFG_DATA_W'(lvl));
    write_word(CFG_FRAME_WIDTH, w);
    write_word(CFG_FRAME_HEIGHT, h);
    cfg.valid <= 1'b0;
    level   = lvl;
    frame_w = eff_size(w, MAX_WIDTH);
    frame_h = eff_size(h, MAX_HEIGHT);
  endtask

  // walk one frame in raster order; optionally resize before word number cut
  task automatic send_frame(fill_e fill, int cut, logic [CFG_DATA_W-1:0] cut_w,
                            logic [CFG_DATA_W-1:0] cut_h);
    int   r;
    int   c;
    int   n;
    int   bt;
    int   bb;
    int   bl;
    int   br;
    logic stop;
    logic bright;
    r    = 0;
    c    = 0;
    n    = 0;
    stop = 1'b0;
    bt   = $urandom_range(0, (frame_h - 1) / 4);
    bb   = $urandom_range((frame_h - 1) * 3 / 4, frame_h - 1);
    bl   = $urandom_range(0, (frame_w - 1) / 4);
    br   = $urandom_range((frame_w - 1) * 3 / 4, frame_w - 1);
    while (!stop) begin
      if (n == cut) set_config(level, cut_w, cut_h);
      case (fill)
        FILL_NOISE:    push_pixel(PIX_W'($urandom_range(0, 255)));
        FILL_DARK:     push_pixel(dark_value());
        FILL_BRIGHT:   push_pixel(bright_value());
        FILL_ONE_DARK: push_pixel((c == r % frame_w) ? dark_value() : bright_value());
        default: begin
          bright = (r >= bt) && (r <= bb) && (c >= bl) && (c <= br);
          if ($urandom_range(0, 15) == 0) bright = !bright;
          push_pixel(bright ? bright_value() : dark_value());
        end
      endcase
      n++;
      if (c + 1 >= frame_w) begin
        c = 0;
        if (r + 1 >= frame_h) stop = 1'b1;
        else r++;
      end else begin
        c++;
      end
    end
  endtask

  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int    rnd;
    int    cut;
    int    pick;
    fill_e fill;
    pix.valid      <= 1'b0;
    pix.gray_pixel <= '0;
    cfg.valid      <= 1'b0;
    cfg.index      <= CFG_DARK_LEVEL;
    cfg.data       <= '0;
    rst_ni         <= 1'b0;
    src_idle_pct  = 28;
    sink_idle_pct = 60;
    sent          = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // widest row used later first, so every column entry read afterwards holds a count
    set_config('0, CFG_DATA_W'(48), CFG_DATA_W'(1));
    send_frame(FILL_NOISE, -1, '0, '0);
    set_config(PIX_W'(255), '0, CFG_DATA_W'(40));
    send_frame(FILL_BOX, -1, '0, '0);
    set_config(DARK_LEVEL_RST, CFG_DATA_W'(4), CFG_DATA_W'(4));
    send_frame(FILL_DARK, -1, '0, '0);
    send_frame(FILL_BRIGHT, -1, '0, '0);
    send_frame(FILL_BOX, 6, CFG_DATA_W'(2), CFG_DATA_W'(3));
    set_config(DARK_LEVEL_RST, CFG_DATA_W'(2), CFG_DATA_W'(3));
    send_frame(FILL_NOISE, 3, CFG_DATA_W'(5), CFG_DATA_W'(4));
    set_config(PIX_W'(128), CFG_DATA_W'(5), CFG_DATA_W'(5));
    send_frame(FILL_ONE_DARK, -1, '0, '0);
    set_config(PIX_W'(128), CFG_DATA_W'(4), CFG_DATA_W'(4));
    send_frame(FILL_ONE_DARK, -1, '0, '0);
    set_config(PIX_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1));
    send_frame(FILL_DARK, -1, '0, '0);
    send_frame(FILL_BRIGHT, -1, '0, '0);

    base = sent;
    while (sent - base < RANDOM_PIXELS) begin
      rnd = sent - base;
      if (rnd < RANDOM_PIXELS / 3) begin
        src_idle_pct  = 28;
        sink_idle_pct = 60;
      end else if (rnd < RANDOM_PIXELS * 2 / 3) begin
        src_idle_pct  = 60;
        sink_idle_pct = 28;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if ($urandom_range(0, 2) == 0) set_config(pick_level(), pick_size(), pick_size());
      pick = $urandom_range(0, 99);
      if (pick < 55) fill = FILL_BOX;
      else if (pick < 70) fill = FILL_NOISE;
      else if (pick < 80) fill = FILL_DARK;
      else if (pick < 90) fill = FILL_BRIGHT;
      else fill = FILL_ONE_DARK;
      cut = -1;
      if ($urandom_range(0, 7) == 0 && frame_w * frame_h > 1) begin
        cut = $urandom_range(1, frame_w * frame_h - 1);
      end
      send_frame(fill, cut, CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(1, 6)));
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
